// ===== hdl/cpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// cpfl_pkg
// Shared types, codes and defaults of the chunk pool free list allocator.
// ----------------------------------------------------------------------------
package cpfl_pkg;

  localparam int SLOT_COUNT            = 256;
  localparam int SLOT_W                = 8;
  localparam int LINK_W                = 9;
  localparam int COUNT_W               = 9;
  localparam int BLOCKS_W              = 5;
  localparam int DEF_CHUNKS_PER_BLOCK  = 16;
  localparam int DEF_MAX_BLOCKS        = 16;

  localparam logic [LINK_W-1:0]   EMPTY_MARK        = 9'd256;
  localparam logic [BLOCKS_W-1:0] BLOCK_LIMIT_RESET = 5'd16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_NOT_INUSE = 2'd2;

  typedef struct packed {
    logic                command;
    logic [SLOT_W-1:0]   chunk_index;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SLOT_W-1:0]   granted_index;
    logic [COUNT_W-1:0]  in_use_count;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic grow_start;
    logic grow_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_grow;
    logic grow_ok;
    logic grow_last;
  } dp_status_t;

endpackage

// ===== hdl/cpfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpfl_ctrl
// Sequencer: accepts a request, runs block linking when needed, then executes.
// ----------------------------------------------------------------------------
module cpfl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cpfl_pkg::dp_status_t  status_i,
  output cpfl_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_GROW  = 2'd2;
  localparam logic [1:0] ST_FETCH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.need_grow && status_i.grow_ok) begin
          cmd_o.grow_start = 1'b1;
          state_d          = ST_GROW;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_GROW: begin
        cmd_o.grow_step = 1'b1;
        if (status_i.grow_last) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_EXEC;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== hdl/cpfl_datapath.sv =====
// ----------------------------------------------------------------------------
// cpfl_datapath
// Link memory, list head, in-use marks, counters and the result register.
// ----------------------------------------------------------------------------
module cpfl_datapath #(
  parameter int CHUNKS_PER_BLOCK = cpfl_pkg::DEF_CHUNKS_PER_BLOCK,
  parameter int MAX_BLOCKS       = cpfl_pkg::DEF_MAX_BLOCKS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cpfl_pkg::req_t                    request_i,
  input  logic                              cfg_we_i,
  input  logic [cpfl_pkg::BLOCKS_W-1:0]     cfg_data_i,
  input  cpfl_pkg::ctrl_cmd_t               cmd_i,
  output cpfl_pkg::dp_status_t              status_o,
  output logic                              result_valid_o,
  output cpfl_pkg::rsp_t                    result_o
);

  localparam int SW   = cpfl_pkg::SLOT_W;
  localparam int LW   = cpfl_pkg::LINK_W;
  localparam int CW   = cpfl_pkg::COUNT_W;
  localparam int BW   = cpfl_pkg::BLOCKS_W;
  localparam int BASE_W = BW + LW;

  logic [LW-1:0] mem [cpfl_pkg::SLOT_COUNT];
  logic [LW-1:0] rdata_q;

  logic [BW-1:0]                   block_limit_q;
  logic [LW-1:0]                   head_q;
  logic [BW-1:0]                   blocks_q;
  logic [CW-1:0]                   count_q;
  logic [cpfl_pkg::SLOT_COUNT-1:0] marks_q;
  cpfl_pkg::req_t                  req_q;
  logic [SW-1:0]                   base_q;
  logic [SW-1:0]                   step_q;
  logic                            valid_q;
  cpfl_pkg::rsp_t                  rsp_q;

  logic [LW-1:0]     limit;
  logic [BASE_W-1:0] base_full;
  logic              head_empty;
  logic              is_free;
  logic              mark_hit;
  logic              we;
  logic [SW-1:0]     waddr;
  logic [LW-1:0]     wdata;

  assign head_empty = head_q[LW-1];
  assign is_free    = (req_q.command == cpfl_pkg::CMD_FREE);
  assign mark_hit   = marks_q[req_q.chunk_index];

  assign limit = (LW'(block_limit_q) > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS)
                                                         : LW'(block_limit_q);
  assign base_full = BASE_W'(blocks_q) * BASE_W'(CHUNKS_PER_BLOCK);

  assign status_o.need_grow = !is_free && head_empty;
  assign status_o.grow_ok   = (LW'(blocks_q) < limit) &&
      ((base_full + BASE_W'(CHUNKS_PER_BLOCK)) <= BASE_W'(cpfl_pkg::SLOT_COUNT));
  assign status_o.grow_last = ({1'b0, step_q} == LW'(CHUNKS_PER_BLOCK - 1));

  always_comb begin
    we    = 1'b0;
    waddr = req_q.chunk_index;
    wdata = head_q;
    if (cmd_i.grow_step) begin
      we    = 1'b1;
      waddr = base_q + step_q;
      wdata = status_o.grow_last ? cpfl_pkg::EMPTY_MARK
                                 : (LW'(base_q) + LW'(step_q) + LW'(1));
    end else if (cmd_i.exec && is_free && mark_hit) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[head_q[SW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= request_i;
    end
    if (cmd_i.grow_start) begin
      base_q <= base_full[SW-1:0];
    end
    if (cmd_i.grow_start) begin
      step_q <= '0;
    end else if (cmd_i.grow_step) begin
      step_q <= step_q + SW'(1);
    end
    if (cmd_i.exec) begin
      rsp_q.status        <= cpfl_pkg::STATUS_OK;
      rsp_q.granted_index <= '0;
      rsp_q.in_use_count  <= count_q;
      if (is_free) begin
        if (!mark_hit) begin
          rsp_q.status <= cpfl_pkg::STATUS_NOT_INUSE;
        end else begin
          rsp_q.in_use_count <= count_q - CW'(1);
        end
      end else if (head_empty) begin
        rsp_q.status <= cpfl_pkg::STATUS_EXHAUSTED;
      end else begin
        rsp_q.granted_index <= head_q[SW-1:0];
        rsp_q.in_use_count  <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_limit_q <= cpfl_pkg::BLOCK_LIMIT_RESET;
      head_q        <= cpfl_pkg::EMPTY_MARK;
      blocks_q      <= '0;
      count_q       <= '0;
      marks_q       <= '0;
      valid_q       <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
      if (cfg_we_i) begin
        block_limit_q <= cfg_data_i;
      end
      if (cmd_i.grow_step && status_o.grow_last) begin
        head_q   <= LW'(base_q);
        blocks_q <= blocks_q + BW'(1);
      end else if (cmd_i.exec) begin
        if (is_free) begin
          if (mark_hit) begin
            head_q                       <= LW'(req_q.chunk_index);
            marks_q[req_q.chunk_index]   <= 1'b0;
            count_q                      <= count_q - CW'(1);
          end
        end else if (!head_empty) begin
          head_q                 <= rdata_q;
          marks_q[head_q[SW-1:0]] <= 1'b1;
          count_q                <= count_q + CW'(1);
        end
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = rsp_q;

endmodule

// ===== hdl/chunk_pool_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// chunk_pool_free_list_allocator
// Fixed-size chunk allocator over a LIFO free list of next links.
//
//   channel   handshake                  payload
//   request   start / busy               request_i   (command, chunk_index)
//   result    result_valid_o strobe      result_o    (status, granted_index,
//                                                     in_use_count)
//   config    cfg_valid_i / cfg_ready_o  cfg_data_i  (block_limit)
//
// For an allocate or free, busy is high for 1 cycle after the
// request is accepted; the result strobe follows in the cycle after, while
// the next request may already be accepted.
// An allocate on an empty list first links a new block if the block limit and
// pool size allow, one link memory write per chunk, then refetches the head.
// Reset is immediate: links need no clearing and in-use marks are flops.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module chunk_pool_free_list_allocator #(
  parameter int CHUNKS_PER_BLOCK = cpfl_pkg::DEF_CHUNKS_PER_BLOCK,
  parameter int MAX_BLOCKS       = cpfl_pkg::DEF_MAX_BLOCKS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  cpfl_pkg::req_t                 request_i,
  output logic                           result_valid_o,
  output cpfl_pkg::rsp_t                 result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cpfl_pkg::BLOCKS_W-1:0]  cfg_data_i
);

  cpfl_pkg::ctrl_cmd_t  cmd;
  cpfl_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  cpfl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (cmd)
  );

  cpfl_datapath #(
    .CHUNKS_PER_BLOCK (CHUNKS_PER_BLOCK),
    .MAX_BLOCKS       (MAX_BLOCKS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .request_i      (request_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
